>>> design/cpof_pkg.sv
// Shared types for the cyclic pattern offset finder.
package cpof_pkg;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // take a new search word and restart the generator
    logic step;    // generate one pattern byte and compare the window
    logic finish;  // capture the result on this step
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;   // the window just formed matches the word in either byte order
    logic last;  // the byte just generated is the last one of the pattern
  } status_t;

  // Pattern alphabets: base characters and last indices.
  localparam logic [7:0] UpperBase = 8'h41;
  localparam logic [7:0] LowerBase = 8'h61;
  localparam logic [7:0] DigitBase = 8'h30;
  localparam logic [4:0] UpperLast = 5'd25;
  localparam logic [4:0] LowerLast = 5'd25;
  localparam logic [3:0] DigitLast = 4'd9;

  localparam int unsigned PosWidth = 15;

endpackage

>>> design/cyclic_pattern_offset_finder.sv
// A search word is looked for from the start of the pattern; a hit ends the search at the first match.
// A miss walks all PATTERN_LEN bytes, one pattern byte per cycle.
// Only one word is in flight: no new word is taken while a search runs or its result waits.
// The next word is taken in the cycle its predecessor's result leaves.
// Reset (rst_ni low, asynchronous) returns the controller to idle and clears the generator.
module cyclic_pattern_offset_finder
  import cpof_pkg::*;
#(
  parameter int unsigned PATTERN_LEN = 20280
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         search_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic [PosWidth-1:0] offset_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencing.
  cpof_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Pattern generation and comparison.
  cpof_dp #(
    .PATTERN_LEN (PATTERN_LEN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .search_word_i (search_word_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .found_o       (found_o),
    .offset_o      (offset_o)
  );

endmodule

>>> design/cpof_ctrl.sv
// Controller state machine for the cyclic pattern offset finder.
module cpof_ctrl
  import cpof_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  // A new beat is taken when idle, or when the waiting result leaves in the same cycle.
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.hit || status_i.last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (accept) begin
          state_d = ST_RUN;
        end else if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
      end
      ST_RUN: begin
        cmd_o.step   = 1'b1;
        cmd_o.finish = status_i.hit || status_i.last;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        cmd_o.load  = accept;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/cpof_dp.sv
// Datapath for the cyclic pattern offset finder: pattern generator, window and result.
module cpof_dp
  import cpof_pkg::*;
#(
  parameter int unsigned PATTERN_LEN = 20280
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         search_word_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic                found_o,
  output logic [PosWidth-1:0] offset_o
);

  localparam logic [PosWidth-1:0] LastPos = PosWidth'(PATTERN_LEN - 1);
  localparam logic [PosWidth-1:0] FirstFullPos = PosWidth'(3);

  logic [4:0]          upper_q, upper_d;
  logic [4:0]          lower_q, lower_d;
  logic [3:0]          digit_q, digit_d;
  logic [1:0]          phase_q, phase_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [31:0]         window_q, window_d;
  logic [31:0]         word_q, rev_q;
  logic                found_q;
  logic [PosWidth-1:0] offset_q;
  logic [7:0]          byte_val;

  // Byte generator and counter advance.
  always_comb begin
    upper_d  = upper_q;
    lower_d  = lower_q;
    digit_d  = digit_q;
    phase_d  = phase_q;
    byte_val = UpperBase + {3'b000, upper_q};
    case (phase_q)
      2'd0: begin
        byte_val = UpperBase + {3'b000, upper_q};
        phase_d  = 2'd1;
      end
      2'd1: begin
        byte_val = LowerBase + {3'b000, lower_q};
        phase_d  = 2'd2;
      end
      default: begin
        byte_val = DigitBase + {4'b0000, digit_q};
        phase_d  = 2'd0;
        if (digit_q >= DigitLast) begin
          digit_d = '0;
          if (lower_q >= LowerLast) begin
            lower_d = '0;
            upper_d = (upper_q >= UpperLast) ? 5'd0 : upper_q + 5'd1;
          end else begin
            lower_d = lower_q + 5'd1;
          end
        end else begin
          digit_d = digit_q + 4'd1;
        end
      end
    endcase
    window_d = {window_q[23:0], byte_val};
    pos_d    = pos_q + PosWidth'(1);
  end

  // Match against the word in both byte orders once four bytes are in.
  assign status_o.hit  = (pos_q >= FirstFullPos) &&
                         ((window_d == word_q) || (window_d == rev_q));
  assign status_o.last = (pos_q == LastPos);

  // Generator state and search word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= '0;
      lower_q  <= '0;
      digit_q  <= '0;
      phase_q  <= '0;
      pos_q    <= '0;
      window_q <= '0;
    end else if (cmd_i.load) begin
      upper_q  <= '0;
      lower_q  <= '0;
      digit_q  <= '0;
      phase_q  <= '0;
      pos_q    <= '0;
      window_q <= '0;
    end else if (cmd_i.step) begin
      upper_q  <= upper_d;
      lower_q  <= lower_d;
      digit_q  <= digit_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= search_word_i;
      rev_q  <= {search_word_i[7:0], search_word_i[15:8],
                 search_word_i[23:16], search_word_i[31:24]};
    end
  end

  // Result register, held until the beat leaves.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_q  <= status_o.hit;
      offset_q <= status_o.hit ? pos_q - FirstFullPos : '0;
    end
  end

  assign found_o  = found_q;
  assign offset_o = offset_q;

endmodule

>>> tb/cpof_checker.sv
// Checker for the cyclic pattern offset finder: predicts answers and compares output beats.
module cpof_checker
  import cpof_pkg::*;
#(
  parameter int unsigned PATTERN_LEN = 20280
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [31:0]         search_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                found_i,
  input  logic [PosWidth-1:0] offset_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 10;

  // One predicted answer, with the word that asked for it.
  typedef struct packed {
    logic [31:0]         word;
    logic                found;
    logic [PosWidth-1:0] offset;
  } answer_t;

  logic [7:0]  pattern_bytes [PATTERN_LEN];
  answer_t     answer_q [$];
  int unsigned failures;

  // Lay the pattern out once, stepping the three alphabet counters.
  initial begin : build_pattern
    logic [4:0] upper_idx;
    logic [4:0] lower_idx;
    logic [3:0] digit_idx;
    logic [1:0] slot;
    upper_idx = '0;
    lower_idx = '0;
    digit_idx = '0;
    slot      = '0;
    for (int unsigned p = 0; p < PATTERN_LEN; p++) begin
      case (slot)
        2'd0: begin
          pattern_bytes[p] = UpperBase + {3'b000, upper_idx};
          slot = 2'd1;
        end
        2'd1: begin
          pattern_bytes[p] = LowerBase + {3'b000, lower_idx};
          slot = 2'd2;
        end
        default: begin
          pattern_bytes[p] = DigitBase + {4'b0000, digit_idx};
          slot = 2'd0;
          // The digit carries into the lowercase letter, which carries into the uppercase one.
          if (digit_idx == DigitLast) begin
            digit_idx = '0;
            if (lower_idx == LowerLast) begin
              lower_idx = '0;
              upper_idx = (upper_idx == UpperLast) ? 5'd0 : upper_idx + 5'd1;
            end else begin
              lower_idx = lower_idx + 5'd1;
            end
          end else begin
            digit_idx = digit_idx + 4'd1;
          end
        end
      endcase
    end
  end

  // Slide a four-byte window from the start and stop at the first match in either order.
  function automatic answer_t locate_word(logic [31:0] word);
    logic [31:0] swapped;
    logic [31:0] window;
    answer_t     ans;
    swapped    = {word[7:0], word[15:8], word[23:16], word[31:24]};
    window     = '0;
    ans        = '0;
    ans.word   = word;
    for (int unsigned p = 0; p < PATTERN_LEN; p++) begin
      window = {window[23:0], pattern_bytes[p]};
      if (p >= 3 && (window == word || window == swapped)) begin
        ans.found  = 1'b1;
        ans.offset = PosWidth'(p - 3);
        return ans;
      end
    end
    return ans;
  endfunction

  // Predict on every input beat and compare every output beat with the oldest prediction.
  always @(posedge clk_i) begin : watch_beats
    answer_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        answer_q = {answer_q, locate_word(search_word_i)};
      end
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          if (failures < ReportLimit) begin
            $display("%0t: result beat with nothing outstanding: found=%0b offset=%0d",
                     $realtime, found_i, offset_i);
          end
          failures = failures + 1;
        end else begin
          want = answer_q.pop_front();
          if (found_i !== want.found || offset_i !== want.offset) begin
            if (failures < ReportLimit) begin
              $display("%0t: word %h: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                       $realtime, want.word, want.found, want.offset, found_i, offset_i);
            end
            failures = failures + 1;
          end
        end
      end
      pending_o    <= answer_q.size();
      fail_count_o <= failures;
    end
  end

endmodule

>>> tb/cyclic_pattern_offset_finder_test.sv
// Testbench top for the cyclic pattern offset finder: clock, reset, stimulus and verdict.
module cyclic_pattern_offset_finder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cpof_pkg::*;

  localparam int unsigned SearchLen   = 20280;
  localparam int unsigned RandomItems = 100;
  localparam int unsigned HoldAfter   = 26;
  localparam int unsigned HoldCycles  = 25000;
  localparam int unsigned CycleLimit  = 10_000_000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [31:0]         search_word;
  logic                out_valid;
  logic                out_ready;
  logic                found;
  logic [PosWidth-1:0] offset;
  int unsigned         pending;
  int unsigned         fail_count;
  int unsigned         sent_count;
  bit                  hold_off;

  cyclic_pattern_offset_finder #(
    .PATTERN_LEN(SearchLen)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .search_word_i(search_word),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .found_o      (found),
    .offset_o     (offset)
  );

  cpof_checker #(
    .PATTERN_LEN(SearchLen)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .search_word_i(search_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .found_i      (found),
    .offset_i     (offset),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Pattern byte at a position, from the triplet number directly.
  function automatic logic [7:0] byte_at(int unsigned pos);
    int unsigned t;
    t = pos / 3;
    case (pos % 3)
      0:       return UpperBase + 8'((t / 260) % 26);
      1:       return LowerBase + 8'((t / 10) % 26);
      default: return DigitBase + 8'(t % 10);
    endcase
  endfunction

  function automatic logic [31:0] window_at(int unsigned pos);
    return {byte_at(pos), byte_at(pos + 1), byte_at(pos + 2), byte_at(pos + 3)};
  endfunction

  function automatic logic [31:0] swap_bytes(logic [31:0] word);
    return {word[7:0], word[15:8], word[23:16], word[31:24]};
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 200);
  endfunction

  // Offer one word after an idle gap and hold it until the beat is taken.
  task automatic send_word(input logic [31:0] word, input int unsigned gap);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    search_word = word;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, forced low while the long hold-off runs.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready = 1'b0;
      end else if (stall_left != 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // One long hold-off on the result side, so that the block fills and refuses new words.
  initial begin : receiver_hold
    hold_off = 1'b0;
    wait (sent_count >= HoldAfter);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off = 1'b0;
  end

  // Give up on a hung run.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] directed [$];
    logic [31:0] word;
    int unsigned roll;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    search_word = '0;
    sent_count  = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed words: first and last windows, the counter carries, both byte orders,
    // and words that never occur, among them the wrap from the last triplet to the first.
    directed = '{window_at(0), swap_bytes(window_at(0)), window_at(1), window_at(2),
                 window_at(28), swap_bytes(window_at(29)), window_at(778),
                 swap_bytes(window_at(779)), window_at(SearchLen / 2),
                 swap_bytes(window_at(SearchLen / 2)), window_at(SearchLen - 4),
                 swap_bytes(window_at(SearchLen - 4)), 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h4141_4141,
                 {byte_at(SearchLen - 3), byte_at(SearchLen - 2), byte_at(SearchLen - 1),
                  byte_at(0)}};
    foreach (directed[i]) send_word(directed[i], pick_gap());

    // Let everything drain before the random part.
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);

    // Random words: mostly real windows near the start, some anywhere, some corrupted or noise.
    for (int unsigned i = 0; i < RandomItems; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        word = window_at($urandom_range(0, 1023));
      end else if (roll < 75) begin
        word = window_at($urandom_range(0, SearchLen - 4));
      end else if (roll < 90) begin
        word = window_at($urandom_range(0, 1023)) ^ (32'd1 << $urandom_range(0, 31));
      end else begin
        word = $urandom();
      end
      if (roll < 90 && $urandom_range(0, 1) == 1) word = swap_bytes(word);
      if (i == RandomItems / 2) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send_word(word, ((i / 16) % 3 == 2) ? 0 : pick_gap());
    end

    // Wait for the last answers, then long enough to catch a stray one.
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SearchLen + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
